>>> sv/b64se_pkg.sv
// Shared types, constants and the alphabet function for the base64 stream encoder.
// No dependencies; every other file imports this package.
`default_nettype none

package b64se_pkg;

   // Depth of the group queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Number of valid bytes in a group
   localparam logic [1:0] GRP_ONE   = 2'd1;
   localparam logic [1:0] GRP_TWO   = 2'd2;
   localparam logic [1:0] GRP_THREE = 2'd3;

   // Byte positions inside a group
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   // Character slots of one encoded group
   localparam logic [1:0] SLOT_0 = 2'd0;
   localparam logic [1:0] SLOT_1 = 2'd1;
   localparam logic [1:0] SLOT_2 = 2'd2;
   localparam logic [1:0] SLOT_3 = 2'd3;

   // ASCII codes
   localparam logic [6:0] CH_UPPER_A = 7'h41;
   localparam logic [6:0] CH_LOWER_A = 7'h61;
   localparam logic [6:0] CH_DIGIT_0 = 7'h30;
   localparam logic [6:0] CH_PLUS    = 7'h2b;
   localparam logic [6:0] CH_SLASH   = 7'h2f;
   localparam logic [6:0] CH_PAD     = 7'h3d;

   // One group handed from front to back
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;   // zero when absent
      logic [7:0] byte2;   // zero when absent
      logic [1:0] count;   // GRP_ONE, GRP_TWO or GRP_THREE
      logic       last;    // group ends the message
   } grp_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Map a 6-bit value onto the standard alphabet
   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = CH_UPPER_A + {1'b0, v};
      end else if (v < 6'd52) begin
         c = CH_LOWER_A + {1'b0, v} - 7'd26;
      end else if (v < 6'd62) begin
         c = CH_DIGIT_0 + {1'b0, v} - 7'd52;
      end else if (v == 6'd62) begin
         c = CH_PLUS;
      end else begin
         c = CH_SLASH;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> sv/b64se_front.sv
// Front end: accepts bytes, holds the partial group and pushes complete groups.
// Depends on b64se_pkg.
`default_nettype none

module b64se_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [7:0]           req_data_byte,
   input  wire                  req_is_last,
   input  b64se_pkg::qstat_type q_stat,
   output logic                 push,
   output b64se_pkg::grp_type   push_grp
);
   import b64se_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic       accept;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   // Classify the byte: hold it, or close the group
   always_comb begin
      pos_in   = pos_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      push     = 1'b0;
      push_grp = '0;
      if (accept) begin
         unique case (pos_ff)
            POS_SECOND: begin
               if (req_is_last) begin
                  push           = 1'b1;
                  push_grp.byte0 = held0_ff;
                  push_grp.byte1 = req_data_byte;
                  push_grp.count = GRP_TWO;
                  push_grp.last  = 1'b1;
                  pos_in         = POS_FIRST;
               end else begin
                  held1_in = req_data_byte;
                  pos_in   = POS_THIRD;
               end
            end
            POS_THIRD: begin
               push           = 1'b1;
               push_grp.byte0 = held0_ff;
               push_grp.byte1 = held1_ff;
               push_grp.byte2 = req_data_byte;
               push_grp.count = GRP_THREE;
               push_grp.last  = req_is_last;
               pos_in         = POS_FIRST;
            end
            default: begin
               // first byte; an unused position counts as the first
               if (req_is_last) begin
                  push           = 1'b1;
                  push_grp.byte0 = req_data_byte;
                  push_grp.count = GRP_ONE;
                  push_grp.last  = 1'b1;
                  pos_in         = POS_FIRST;
               end else begin
                  held0_in = req_data_byte;
                  pos_in   = POS_SECOND;
               end
            end
         endcase
      end
   end

   // Advance position
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_FIRST;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Hold bytes of the open group
   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

`default_nettype wire

>>> sv/b64se_queue.sv
// Short queue of byte groups between front and back.
// Depends on b64se_pkg.
`default_nettype none

module b64se_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  b64se_pkg::grp_type   push_grp,
   input  wire                  pop,
   output b64se_pkg::grp_type   head_grp,
   output b64se_pkg::qstat_type q_stat
);
   import b64se_pkg::*;

   grp_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign q_stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_grp     = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store pushed group
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_grp;
      end
   end

endmodule

`default_nettype wire

>>> sv/b64se_back.sv
// Back end: walks the head group one character per cycle into the output register, unless stalled.
// Depends on b64se_pkg.
`default_nettype none

module b64se_back (
   input  wire                  clock,
   input  wire                  reset,
   input  b64se_pkg::grp_type   head_grp,
   input  b64se_pkg::qstat_type q_stat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [6:0]           rsp_out_char,
   output logic                 rsp_out_last
);
   import b64se_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic [5:0] sextet;
   logic       is_pad;

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;
   assign load         = !valid_ff || rsp_ready;

   // Select the six bits and pad flag for the current slot
   always_comb begin
      sextet = '0;
      is_pad = 1'b0;
      unique case (slot_ff)
         SLOT_0: sextet = head_grp.byte0[7:2];
         SLOT_1: sextet = {head_grp.byte0[1:0], head_grp.byte1[7:4]};
         SLOT_2: begin
            sextet = {head_grp.byte1[3:0], head_grp.byte2[7:6]};
            is_pad = (head_grp.count == GRP_ONE);
         end
         SLOT_3: begin
            sextet = head_grp.byte2[5:0];
            is_pad = (head_grp.count != GRP_THREE);
         end
         default: sextet = '0;
      endcase
   end

   // Load next character when the output register frees up
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            char_in = is_pad ? CH_PAD : b64_char(sextet);
            last_in = (slot_ff == SLOT_3) && head_grp.last;
            slot_in = slot_ff + 1'b1;
            pop     = (slot_ff == SLOT_3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= SLOT_0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Hold output payload
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

>>> sv/base64_stream_encoder_unit.sv
// Top level of the base64 stream encoder: front end, group queue and back end.
// Depends on b64se_pkg, b64se_front, b64se_queue and b64se_back.
`default_nettype none

// Base64 (standard alphabet, '=' padding) encoder for a byte stream. One byte
// enters per item with a last flag; every third byte, or a last byte, closes a
// group that yields four characters, padded with '=' when the message ends
// early, with rsp_out_last on the fourth character of the last group. Bytes
// are accepted one per cycle as long as the two-entry group queue has room.
// Characters leave one per cycle while rsp_ready is high, from a registered
// output stage, so the sustained input rate is three bytes per four characters,
// set by the single character slot of the back end. A closing byte is stored in
// the queue, and its first character is then registered in the output stage.
module base64_stream_encoder_unit (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_data_byte,
   input  wire        req_is_last,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_out_last
);
   import b64se_pkg::*;

   qstat_type q_stat;
   grp_type   push_grp;
   grp_type   head_grp;
   logic      push;
   logic      pop;

   b64se_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .q_stat        (q_stat),
      .push          (push),
      .push_grp      (push_grp)
   );

   b64se_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .pop      (pop),
      .head_grp (head_grp),
      .q_stat   (q_stat)
   );

   b64se_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_grp     (head_grp),
      .q_stat       (q_stat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

>>> sv/b64se_checker.sv
// Port-level checks for the base64 stream encoder, bound to the top level.
// Depends on b64se_pkg.
`default_nettype none

module b64se_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [6:0] rsp_out_char,
   input wire       rsp_out_last
);
   import b64se_pkg::*;

   // Stalled output holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                  && $stable(rsp_out_last))
      else $error("output changed while stalled");

   // Only alphabet characters or the pad leave the block
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char >= CH_UPPER_A && rsp_out_char <= 7'h5a)
                 || (rsp_out_char >= CH_LOWER_A && rsp_out_char <= 7'h7a)
                 || (rsp_out_char >= CH_DIGIT_0 && rsp_out_char <= 7'h39)
                 || rsp_out_char == CH_PLUS || rsp_out_char == CH_SLASH
                 || rsp_out_char == CH_PAD)
      else $error("illegal output character");

   // Output is empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("output valid after reset");

   // A pad that is not flagged last is followed by another pad
   a_pad_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_out_char == CH_PAD && !rsp_out_last
      |=> !rsp_valid || rsp_out_char == CH_PAD)
      else $error("pad not followed by pad");

endmodule

bind base64_stream_encoder_unit b64se_checker u_b64se_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_char (rsp_out_char),
   .rsp_out_last (rsp_out_last)
);

`default_nettype wire
